>>> rtl/icf_pkg.sv
// Shared types and constants of the IR constant folder.
// Used by icf_front, icf_queue, icf_back and ir_constant_folder_top.
package icf_pkg;

  localparam int KIND_W  = 3;
  localparam int REG_W   = 7;
  localparam int VAL_W   = 64;
  localparam int OP_W    = 2;
  localparam int CNT_W   = 6;
  localparam int REG_IDS = 2 ** REG_W;

  localparam int DEF_NUM_REGS    = 128;
  localparam int DEF_MAX_PROGRAM = 32;

  localparam int QDEPTH = 4;
  localparam int Q_AW   = $clog2(QDEPTH);
  localparam int Q_CW   = $clog2(QDEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_CONST  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BINOP  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_COPY   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RETURN = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOP    = 3'd4;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;

  typedef enum logic [1:0] {
    CLS_CONST,
    CLS_BINOP,
    CLS_COPY,
    CLS_PASS
  } icf_class_t;

  // One classified instruction as it waits in the queue.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    icf_class_t        cls;
    logic              op_ok;
    logic [REG_W-1:0]  dest;
    logic [REG_W-1:0]  left;
    logic [REG_W-1:0]  right;
    logic [REG_W-1:0]  source;
    logic [REG_W-1:0]  d_idx;
    logic [REG_W-1:0]  l_idx;
    logic [REG_W-1:0]  r_idx;
    logic [REG_W-1:0]  s_idx;
    logic [VAL_W-1:0]  value;
    logic [OP_W-1:0]   op;
    logic              last;
  } icf_item_t;

  // One rewritten instruction on its way out.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [REG_W-1:0]  dest;
    logic [VAL_W-1:0]  value;
    logic [OP_W-1:0]   op;
    logic [REG_W-1:0]  left;
    logic [REG_W-1:0]  right;
    logic [REG_W-1:0]  source;
    logic              folded;
    logic [CNT_W-1:0]  count;
    logic              last;
  } icf_result_t;

endpackage

>>> rtl/icf_front.sv
// Front end: classifies an incoming instruction and maps register numbers.
// Depends on icf_pkg.
module icf_front
  import icf_pkg::*;
#(
  parameter int NUM_REGS = DEF_NUM_REGS
) (
  input  logic [KIND_W-1:0] kind,
  input  logic [REG_W-1:0]  dest_reg,
  input  logic [VAL_W-1:0]  const_value,
  input  logic [OP_W-1:0]   alu_op,
  input  logic [REG_W-1:0]  left_reg,
  input  logic [REG_W-1:0]  right_reg,
  input  logic [REG_W-1:0]  source_reg,
  input  logic              last,
  output icf_item_t         item
);

  localparam int ND = (NUM_REGS < REG_IDS) ? NUM_REGS : REG_IDS;

  // Register number to table slot, wrapping past the register count.
  logic [REG_W-1:0] idx_map [REG_IDS];

  for (genvar i = 0; i < REG_IDS; i++) begin : g_map
    assign idx_map[i] = REG_W'(i % ND);
  end

  always_comb begin
    item        = '0;
    item.kind   = kind;
    item.dest   = dest_reg;
    item.left   = left_reg;
    item.right  = right_reg;
    item.source = source_reg;
    item.d_idx  = idx_map[dest_reg];
    item.l_idx  = idx_map[left_reg];
    item.r_idx  = idx_map[right_reg];
    item.s_idx  = idx_map[source_reg];
    item.value  = const_value;
    item.op     = alu_op;
    item.last   = last;
    item.op_ok  = alu_op inside {OP_ADD, OP_SUB, OP_MUL};
    case (kind)
      KIND_CONST: item.cls = CLS_CONST;
      KIND_BINOP: item.cls = CLS_BINOP;
      KIND_COPY:  item.cls = CLS_COPY;
      default:    item.cls = CLS_PASS;
    endcase
  end

endmodule

>>> rtl/icf_queue.sv
// Short queue between the front end and the back end.
// Depends on icf_pkg.
module icf_queue
  import icf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  icf_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output icf_item_t out_item
);

  icf_item_t        slots [QDEPTH];
  logic [Q_AW-1:0]  wr_ptr;
  logic [Q_AW-1:0]  rd_ptr;
  logic [Q_CW-1:0]  count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != Q_CW'(QDEPTH));
  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/icf_back.sv
// Back end: mark table, value memory, fold datapath and output register.
// Depends on icf_pkg.
module icf_back
  import icf_pkg::*;
#(
  parameter int NUM_REGS    = DEF_NUM_REGS,
  parameter int MAX_PROGRAM = DEF_MAX_PROGRAM
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  icf_item_t   q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output icf_result_t result
);

  localparam int ND = (NUM_REGS < REG_IDS) ? NUM_REGS : REG_IDS;
  localparam int IW = $clog2(ND);
  localparam logic [CNT_W-1:0] CNT_CEIL =
    CNT_W'((MAX_PROGRAM < 63) ? MAX_PROGRAM : 63);

  // Issue stage state
  logic [ND-1:0]     marks;
  logic [ND-1:0]     marks_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_new;
  logic [VAL_W-1:0]  vmem [ND];

  logic [IW-1:0]     di;
  logic [IW-1:0]     li;
  logic [IW-1:0]     ri;
  logic [IW-1:0]     si;
  logic [IW-1:0]     rd_a_addr;
  logic              fold;
  logic              copy_hit;
  logic              wr_en;
  logic              defines;
  logic              hazard;
  logic              issue;
  logic              pipe_en;

  // Read stage registers
  logic              e1_valid;
  icf_item_t         e1_item;
  logic              e1_fold;
  logic              e1_copy;
  logic              e1_wr;
  logic [CNT_W-1:0]  e1_cnt;
  logic [IW-1:0]     e1_a_addr;
  logic [IW-1:0]     e1_b_addr;
  logic [VAL_W-1:0]  rd_a;
  logic [VAL_W-1:0]  rd_b;

  // Write bypass: the write that happened at the edge of the last read
  logic              wb_valid;
  logic [IW-1:0]     wb_addr;
  logic [VAL_W-1:0]  wb_data;

  logic [VAL_W-1:0]  a_val;
  logic [VAL_W-1:0]  b_val;
  logic [VAL_W-1:0]  addsub;
  logic [VAL_W-1:0]  pp_ll_next;
  logic [31:0]       pp_lh_next;
  logic [31:0]       pp_hl_next;
  logic [VAL_W-1:0]  e2_val_next;

  // Execute stage registers
  logic              e2_valid;
  icf_item_t         e2_item;
  logic              e2_fold;
  logic              e2_wr;
  logic              e2_mul;
  logic [CNT_W-1:0]  e2_cnt;
  logic [IW-1:0]     e2_dest;
  logic [VAL_W-1:0]  e2_val;
  logic [VAL_W-1:0]  pp_ll;
  logic [31:0]       pp_lh;
  logic [31:0]       pp_hl;
  logic [VAL_W-1:0]  mul_res;
  logic [VAL_W-1:0]  wr_val;

  assign pipe_en = !out_valid || out_ready;

  // Issue: marks decide folding, so they update here one item at a time.
  always_comb begin
    di        = q_item.d_idx[IW-1:0];
    li        = q_item.l_idx[IW-1:0];
    ri        = q_item.r_idx[IW-1:0];
    si        = q_item.s_idx[IW-1:0];
    fold      = (q_item.cls == CLS_BINOP) && q_item.op_ok && marks[li] && marks[ri];
    copy_hit  = (q_item.cls == CLS_COPY) && marks[si];
    wr_en     = (q_item.cls == CLS_CONST) || fold || copy_hit;
    defines   = (q_item.cls == CLS_CONST) || (q_item.cls == CLS_BINOP) ||
                (q_item.cls == CLS_COPY);
    rd_a_addr = (q_item.cls == CLS_COPY) ? si : li;
    // Hold on a value still one stage short of the memory write.
    hazard    = e1_valid && e1_wr &&
                (((fold || copy_hit) && (e1_item.d_idx[IW-1:0] == rd_a_addr)) ||
                 (fold && (e1_item.d_idx[IW-1:0] == ri)));
    issue     = q_valid && pipe_en && !hazard;
    cnt_new   = (fold && (cnt < CNT_CEIL)) ? cnt + 1'b1 : cnt;
    marks_next = marks;
    if (defines) begin
      marks_next[di] = wr_en;
    end
    if (q_item.last) begin
      marks_next = '0;
    end
  end

  assign q_ready = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      marks <= '0;
      cnt   <= '0;
    end else if (issue) begin
      marks <= marks_next;
      cnt   <= q_item.last ? '0 : cnt_new;
    end
  end

  // Value memory: two registered reads, one write from the execute stage.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      rd_a <= vmem[rd_a_addr];
      rd_b <= vmem[ri];
      if (e2_valid && e2_wr) begin
        vmem[e2_dest] <= wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      e1_item   <= q_item;
      e1_fold   <= fold;
      e1_copy   <= copy_hit;
      e1_wr     <= wr_en;
      e1_cnt    <= cnt_new;
      e1_a_addr <= rd_a_addr;
      e1_b_addr <= ri;
      wb_addr   <= e2_dest;
      wb_data   <= wr_val;
    end
  end

  // Read stage: bypass, add/sub and 32-bit partial products.
  always_comb begin
    a_val = (wb_valid && (wb_addr == e1_a_addr)) ? wb_data : rd_a;
    b_val = (wb_valid && (wb_addr == e1_b_addr)) ? wb_data : rd_b;
    addsub     = (e1_item.op == OP_SUB) ? a_val - b_val : a_val + b_val;
    pp_ll_next = a_val[31:0] * b_val[31:0];
    pp_lh_next = a_val[31:0] * b_val[63:32];
    pp_hl_next = a_val[63:32] * b_val[31:0];
    if (e1_fold && (e1_item.op != OP_MUL)) begin
      e2_val_next = addsub;
    end else if (e1_copy) begin
      e2_val_next = a_val;
    end else begin
      e2_val_next = e1_item.value;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      e2_item <= e1_item;
      e2_fold <= e1_fold;
      e2_wr   <= e1_wr;
      e2_mul  <= e1_fold && (e1_item.op == OP_MUL);
      e2_cnt  <= e1_cnt;
      e2_dest <= e1_item.d_idx[IW-1:0];
      e2_val  <= e2_val_next;
      pp_ll   <= pp_ll_next;
      pp_lh   <= pp_lh_next;
      pp_hl   <= pp_hl_next;
    end
  end

  // Execute stage: finish the product, write back, load the output register.
  assign mul_res = pp_ll + {pp_lh + pp_hl, 32'b0};
  assign wr_val  = e2_mul ? mul_res : e2_val;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      result.kind   <= e2_fold ? KIND_CONST : e2_item.kind;
      result.dest   <= e2_item.dest;
      result.value  <= e2_fold ? wr_val : e2_item.value;
      result.op     <= e2_item.op;
      result.left   <= e2_item.left;
      result.right  <= e2_item.right;
      result.source <= e2_item.source;
      result.folded <= e2_fold;
      result.count  <= e2_cnt;
      result.last   <= e2_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid  <= 1'b0;
      e2_valid  <= 1'b0;
      out_valid <= 1'b0;
      wb_valid  <= 1'b0;
    end else if (pipe_en) begin
      e1_valid  <= issue;
      e2_valid  <= e1_valid;
      out_valid <= e2_valid;
      wb_valid  <= e2_valid && e2_wr;
    end
  end

endmodule

>>> rtl/ir_constant_folder_top.sv
// Top level of the streaming IR constant folder.
// Depends on icf_pkg, icf_front, icf_queue and icf_back.

// Constant folder for an SSA-form instruction stream. Each accepted
// instruction yields exactly one result transaction in order: binops whose
// two operands hold known constants come out rewritten as consts carrying
// the add, subtract or multiply result (wrapping at 64 bits), with the
// folded flag set and the running fold count of the current program. The
// transaction with tlast set ends a program; all known marks and the count
// clear after it. The block takes one instruction per clock while its queue
// is not full. A binop that folds, or a copy of a known register, that reads
// the register defined by the instruction immediately ahead of it is held at
// issue, since the value memory is written from the third stage and
// forwarded from there. A result passes from the queue through the read and
// execute stage registers into the output register before it is offered; a
// four-entry queue keeps the input open while the output stalls, until it
// fills. No clearing pass is needed after reset.
module ir_constant_folder_top
  import icf_pkg::*;
#(
  parameter int NUM_REGS    = DEF_NUM_REGS,
  parameter int MAX_PROGRAM = DEF_MAX_PROGRAM
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // dest_reg[6:0], const_value[70:7], alu_op[72:71], left_reg[79:73],
  // right_reg[86:80], source_reg[93:87], zero[95:94]
  input  logic [95:0]  s_axis_tdata,
  // kind[2:0]
  input  logic [2:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_dest[6:0], out_value[70:7], out_op[72:71], out_left[79:73],
  // out_right[86:80], out_source[93:87], folds_so_far[99:94], zero[103:100]
  output logic [103:0] m_axis_tdata,
  // out_kind[2:0], was_folded[3]
  output logic [3:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  icf_item_t   in_item;
  icf_item_t   q_item;
  logic        q_valid;
  logic        q_ready;
  icf_result_t result;

  // Classify and map register numbers on the way in.
  icf_front #(
    .NUM_REGS (NUM_REGS)
  ) u_front (
    .kind        (s_axis_tuser),
    .dest_reg    (s_axis_tdata[6:0]),
    .const_value (s_axis_tdata[70:7]),
    .alu_op      (s_axis_tdata[72:71]),
    .left_reg    (s_axis_tdata[79:73]),
    .right_reg   (s_axis_tdata[86:80]),
    .source_reg  (s_axis_tdata[93:87]),
    .last        (s_axis_tlast),
    .item        (in_item)
  );

  // Hold classified instructions until the back end issues them.
  icf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  // Track known constants, fold, and drive the output register.
  icf_back #(
    .NUM_REGS    (NUM_REGS),
    .MAX_PROGRAM (MAX_PROGRAM)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .result    (result)
  );

  // Pack the result transaction.
  assign m_axis_tdata = {4'b0, result.count, result.source, result.right,
                         result.left, result.op, result.value, result.dest};
  assign m_axis_tuser = {result.folded, result.kind};
  assign m_axis_tlast = result.last;

endmodule
